/* hw/rtl/lpb_pkg.sv */
// lpb_pkg: shared types and constants for the largest-prime-below search.
// Used by lpb_ctrl, lpb_dp and largest_prime_below; depends on nothing.
`timescale 1ns / 1ps

package lpb_pkg;

    localparam int LPB_VALUE_BITS = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_BOUND,
        ST_DIV,
        ST_CHECK,
        ST_DONE
    } lpb_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_limit;
        logic dec_cand;
        logic init_div;
        logic start_rem;
        logic rem_step;
        logic next_div;
        logic load_out;
    } lpb_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic cand_even;
        logic sq_above;
        logic rem_last;
        logic rem_zero;
    } lpb_status_t;

endpackage

/* hw/rtl/largest_prime_below.sv */
// largest_prime_below: one request in, one result out. Latency is data dependent:
// an even candidate is stepped down in the test state; an odd one passes the test state
// and then, for each odd trial divisor tried, a bound check, a one-bit-a-cycle remainder
// and a check; a last bound check and an output load report the prime. One request at
// a time: the next is taken the cycle after the result is loaded, while it may wait.
// Reset (aresetn, synchronous, active low) returns to idle and drops any result.
`timescale 1ns / 1ps

module largest_prime_below
    import lpb_pkg::*;
#(
    parameter int VALUE_BITS = LPB_VALUE_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_limit,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VALUE_BITS-1:0] m_prime
);

    lpb_cmd_t    cmd;
    lpb_status_t status;

    lpb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lpb_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_limit (s_limit),
        .status  (status),
        .m_prime (m_prime)
    );

endmodule

/* hw/rtl/lpb_dp.sv */
// lpb_dp: datapath of the prime search: candidate, odd divisor with its square,
// and a bit-serial remainder unit. Depends on lpb_pkg; driven by lpb_ctrl.
`timescale 1ns / 1ps

module lpb_dp
    import lpb_pkg::*;
#(
    parameter int VALUE_BITS = LPB_VALUE_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lpb_cmd_t              cmd,
    input  logic [VALUE_BITS-1:0] s_limit,
    output lpb_status_t           status,
    output logic [VALUE_BITS-1:0] m_prime
);

    localparam int CNT_BITS = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] cand_reg,  cand_next;
    logic [VALUE_BITS-1:0] div_reg,   div_next;
    logic [VALUE_BITS+1:0] sq_reg,    sq_next;
    logic [VALUE_BITS:0]   rem_reg,   rem_next;
    logic [CNT_BITS-1:0]   cnt_reg,   cnt_next;
    logic [VALUE_BITS-1:0] out_reg,   out_next;
    logic [VALUE_BITS:0]   rem_shift;

    assign rem_shift = {rem_reg[VALUE_BITS-1:0], cand_reg[cnt_reg]};

    always_comb begin
        cand_next = cand_reg;
        div_next  = div_reg;
        sq_next   = sq_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        out_next  = out_reg;
        if (cmd.load_limit) begin
            // limits of four and below leave only the floor answer
            cand_next = (s_limit > VALUE_BITS'(4)) ? s_limit - VALUE_BITS'(1)
                                                   : VALUE_BITS'(3);
        end
        if (cmd.dec_cand) begin
            cand_next = cand_reg - VALUE_BITS'(1);
        end
        if (cmd.init_div) begin
            div_next = VALUE_BITS'(3);
            sq_next  = (VALUE_BITS + 2)'(9);
        end
        if (cmd.next_div) begin
            // (d+2)^2 = d^2 + 4d + 4
            div_next = div_reg + VALUE_BITS'(2);
            sq_next  = sq_reg + {div_reg, 2'b00} + (VALUE_BITS + 2)'(4);
        end
        if (cmd.start_rem) begin
            rem_next = '0;
            cnt_next = CNT_BITS'(VALUE_BITS - 1);
        end
        if (cmd.rem_step) begin
            rem_next = (rem_shift >= {1'b0, div_reg}) ? rem_shift - {1'b0, div_reg}
                                                      : rem_shift;
            cnt_next = cnt_reg - CNT_BITS'(1);
        end
        if (cmd.load_out) begin
            out_next = cand_reg;
        end
    end

    always_ff @(posedge aclk) begin
        cand_reg <= cand_next;
        div_reg  <= div_next;
        sq_reg   <= sq_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        out_reg  <= out_next;
    end

    assign status.cand_even = ~cand_reg[0];
    assign status.sq_above  = sq_reg > {2'b00, cand_reg};
    assign status.rem_last  = cnt_reg == '0;
    assign status.rem_zero  = rem_reg == '0;
    assign m_prime          = out_reg;

    // three is always prime, so the search never steps below it
    a_cand_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.dec_cand |-> cand_reg > VALUE_BITS'(3))
        else $error("candidate stepped below three");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rem_step |-> rem_reg < {1'b0, div_reg})
        else $error("partial remainder not below divisor");

    a_div_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rem_step |-> div_reg[0])
        else $error("even trial divisor");

endmodule

/* hw/rtl/lpb_ctrl.sv */
// lpb_ctrl: state machine that sequences candidates, trial divisors and the
// serial remainder in lpb_dp, and owns the request handshakes. Depends on lpb_pkg.
`timescale 1ns / 1ps

module lpb_ctrl
    import lpb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  lpb_status_t status,
    output lpb_cmd_t    cmd
);

    lpb_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_TEST;
            end
            ST_TEST: begin
                if (!status.cand_even) state_next = ST_BOUND;
            end
            ST_BOUND: begin
                state_next = status.sq_above ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                if (status.rem_last) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = status.rem_zero ? ST_TEST : ST_BOUND;
            end
            ST_DONE: begin
                if (slot_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready        = 1'b1;
                cmd.load_limit = s_valid;
            end
            ST_TEST: begin
                cmd.dec_cand = status.cand_even;
                cmd.init_div = !status.cand_even;
            end
            ST_BOUND: begin
                cmd.start_rem = !status.sq_above;
            end
            ST_DIV: begin
                cmd.rem_step = 1'b1;
            end
            ST_CHECK: begin
                // divisor hit: drop this candidate, else try the next odd divisor
                cmd.dec_cand = status.rem_zero;
                cmd.next_div = !status.rem_zero;
            end
            ST_DONE: begin
                cmd.load_out = slot_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !(out_valid_reg && !m_ready))
        else $error("result overwritten before it was taken");

    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");

    a_done_after_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BOUND && status.sq_above) |=> state_reg == ST_DONE)
        else $error("prime candidate not reported");

endmodule

/* dv/largest_prime_below_tb.sv */
// largest_prime_below_tb: self-checking bench for the largest-prime-below search block.
// Drives limits through a directed table and a random set, checked against typed-in answers or trial division.
// Depends on lpb_pkg and largest_prime_below.
`timescale 1ns / 1ps

module largest_prime_below_tb;
    import lpb_pkg::*;

    localparam int W = LPB_VALUE_BITS;
    localparam logic [63:0] FLOOR_PRIME = 64'd3;
    localparam int RANDOM_REQUESTS = 80;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic [W-1:0] limit;
        logic [W-1:0] prime;
        bit           known;
    } limit_row_t;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_valid;
    logic         s_ready;
    logic [W-1:0] s_limit;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [W-1:0] m_prime;

    logic [W-1:0] expected_primes[$];
    int           error_count = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;

    // Typed-in answers only where they are obvious: tiny limits, squares just
    // below the limit, and the largest 16- and 32-bit primes.
    limit_row_t directed_rows[] = '{
        '{32'd0,          32'd3,          1'b1},
        '{32'd1,          32'd3,          1'b1},
        '{32'd2,          32'd3,          1'b1},
        '{32'd3,          32'd3,          1'b1},
        '{32'd4,          32'd3,          1'b1},
        '{32'd5,          32'd3,          1'b1},
        '{32'd6,          32'd5,          1'b1},
        '{32'd7,          32'd5,          1'b1},
        '{32'd8,          32'd7,          1'b1},
        '{32'd10,         32'd7,          1'b1},
        '{32'd11,         32'd7,          1'b1},
        '{32'd26,         32'd23,         1'b1},
        '{32'd50,         32'd47,         1'b1},
        '{32'd122,        32'd113,        1'b1},
        '{32'd170,        32'd167,        1'b1},
        '{32'd1000,       32'd0,          1'b0},
        '{32'd65536,      32'd65521,      1'b1},
        '{32'h0010_0000,  32'd0,          1'b0},
        '{32'h0001_2345,  32'd0,          1'b0},
        '{32'hFFFF_FFFF,  32'hFFFF_FFFB,  1'b1}
    };

    largest_prime_below dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_limit (s_limit),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_prime (m_prime)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic bit is_prime_by_division(input logic [63:0] n);
        logic [63:0] d;
        if (n[0] == 1'b0) begin
            return n == 64'd2;
        end
        for (d = 64'd3; d <= n / d; d += 64'd2) begin
            if (n % d == 64'd0) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [W-1:0] top_prime_under(input logic [W-1:0] lim);
        logic [63:0] cand;
        if (64'(lim) > FLOOR_PRIME + 64'd1) begin
            for (cand = 64'(lim) - 64'd1; cand >= FLOOR_PRIME; cand--) begin
                if (is_prime_by_division(cand)) begin
                    return W'(cand);
                end
            end
        end
        return W'(FLOOR_PRIME);
    endfunction

    // Called right after a rising edge; returns at the edge that accepts the request.
    task automatic send_limit(input logic [W-1:0] lim, input logic [W-1:0] prime, input bit known);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_limit <= lim;
        do @(posedge aclk); while (!s_ready);
        expected_primes.push_back(known ? prime : top_prime_under(lim));
    endtask

    function automatic logic [W-1:0] random_limit();
        int r;
        int bits;
        r = $urandom_range(99);
        if (r < 70) begin
            bits = $urandom_range(12, 2);
        end else if (r < 95) begin
            bits = $urandom_range(17, 13);
        end else begin
            bits = $urandom_range(20, 18);
        end
        return W'($urandom) >> (W - bits);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        logic [W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_primes.size() == 0) begin
                $error("prime: no request pending, got %0d", m_prime);
                error_count++;
            end else begin
                want = expected_primes.pop_front();
                if (m_prime !== want) begin
                    $error("prime: expected %0d, got %0d", want, m_prime);
                    error_count++;
                end
            end
        end
    end

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_limit <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 10;
        recv_idle_pct = 45;
        foreach (directed_rows[i]) begin
            send_limit(directed_rows[i].limit, directed_rows[i].prime, directed_rows[i].known);
        end

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            // Swap idle rates after a third, then run with no idling at all.
            if (i == RANDOM_REQUESTS / 3) begin
                send_idle_pct = 45;
                recv_idle_pct = 10;
            end else if (i == 2 * RANDOM_REQUESTS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_limit(random_limit(), '0, 1'b0);
        end
        s_valid <= 1'b0;

        while (expected_primes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("largest_prime_below_tb: done, clean");
        end else begin
            $display("largest_prime_below_tb: done, errors");
        end
        $finish;
    end

    // Timeout for a hung run, set long enough for the long search of the all-ones limit.
    initial begin
        #100_000_000;
        $display("largest_prime_below_tb: done, errors");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/lpb_pkg.sv
hw/rtl/lpb_dp.sv
hw/rtl/lpb_ctrl.sv
hw/rtl/largest_prime_below.sv
dv/largest_prime_below_tb.sv
